// ===== rtl/core/scbp_pkg.sv =====
// ----------------------------------------------------------------------------
// scbp_pkg
// types, constants and helpers shared by the size class block pool core
// ----------------------------------------------------------------------------
package scbp_pkg;

   localparam int CLASS_COUNT  = 16;
   localparam int HANDLE_COUNT = 4096;

   localparam int CLS_W    = $clog2(CLASS_COUNT);
   localparam int HANDLE_W = $clog2(HANDLE_COUNT);
   localparam int LINK_W   = HANDLE_W + 1;
   localparam int CNT_W    = 13;
   localparam int BS_W     = 26;
   localparam int SIZE_W   = 32;
   localparam int HELD_W   = 34;
   localparam int FB_W     = CNT_W + BS_W;

   localparam int BASE_SHIFT   = 10;
   localparam int SMALL_CLASS  = 7;
   localparam int MEDIUM_CLASS = 13;
   localparam int SPAN_SHIFT   = 24;
   localparam int REFILL_SMALL = 128;

   localparam logic [LINK_W-1:0] END_MARK    = LINK_W'(HANDLE_COUNT);
   localparam logic [FB_W-1:0]   TRIM_FLOOR  = FB_W'(64'd262144);
   localparam logic [FB_W-1:0]   REFILL_THR  = FB_W'(64'd16777216);
   localparam logic [31:0]       POOL_RESET  = 32'h8000_0000;

   typedef struct packed {
      logic              kind;
      logic [SIZE_W-1:0] size;
      logic [11:0]       handle;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] granted_handle;
      logic [25:0] granted_size;
   } rsp_type;

   typedef enum logic [1:0] {
      RSP_OK       = 2'd0,
      RSP_NO_FIT   = 2'd1,
      RSP_NO_SPACE = 2'd2
   } rsp_code_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_INIT_WR,
      OP_LOAD,
      OP_RELEASE,
      OP_READ_HEAD,
      OP_ALLOC_POP,
      OP_TRIM_START,
      OP_TRIM_POP,
      OP_REFILL_START,
      OP_READ_SPARE,
      OP_REFILL_PUSH,
      OP_CUR_ZERO,
      OP_CUR_INC,
      OP_CUR_REQ
   } op_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DECIDE,
      ST_ALLOC_RD,
      ST_ALLOC_POP,
      ST_REFILL_CHK,
      ST_REFILL_RECHK,
      ST_REFILL_START,
      ST_REFILL_LOOP,
      ST_REFILL_PUSH,
      ST_TRIM_START,
      ST_TRIM_LOOP,
      ST_TRIM_POP,
      ST_RESP
   } state_type;

   typedef struct packed {
      op_type       op;
      logic         thr_all;
      logic         rsp_load;
      rsp_code_type rsp_code;
   } cmd_type;

   typedef struct packed {
      logic init_last;
      logic found;
      logic is_release;
      logic head_end;
      logic spare_end;
      logic count_zero;
      logic pushed_any;
      logic over_budget;
      logic cur_last;
   } stat_type;

   function automatic logic [BS_W-1:0] class_bytes(input logic [CLS_W-1:0] c);
      class_bytes = BS_W'(1) << (BASE_SHIFT + int'(c));
   endfunction

endpackage

// ===== rtl/core/scbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// scbp_ctrl
// sequencer for allocate, release, refill and trim of the block pool
// ----------------------------------------------------------------------------
module scbp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  scbp_pkg::stat_type stat,
   output scbp_pkg::cmd_type  cmd
);

   scbp_pkg::state_type    state_ff, state_in;
   scbp_pkg::rsp_code_type code_ff, code_in;
   logic                   trim_all_ff, trim_all_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scbp_pkg::ST_INIT;
         code_ff      <= scbp_pkg::RSP_OK;
         trim_all_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         code_ff      <= code_in;
         trim_all_ff  <= trim_all_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      trim_all_in  = trim_all_ff;
      cmd.op       = scbp_pkg::OP_NONE;
      cmd.thr_all  = trim_all_ff;
      cmd.rsp_load = 1'b0;
      cmd.rsp_code = code_ff;
      req_ready    = 1'b0;
      case (state_ff)
         scbp_pkg::ST_INIT: begin
            cmd.op = scbp_pkg::OP_INIT_WR;
            if (stat.init_last) state_in = scbp_pkg::ST_IDLE;
         end
         scbp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = scbp_pkg::OP_LOAD;
               state_in = scbp_pkg::ST_DECIDE;
            end
         end
         scbp_pkg::ST_DECIDE: begin
            if (!stat.found) begin
               code_in  = scbp_pkg::RSP_NO_FIT;
               state_in = scbp_pkg::ST_RESP;
            end else if (stat.is_release) begin
               cmd.op      = scbp_pkg::OP_RELEASE;
               trim_all_in = 1'b0;
               state_in    = scbp_pkg::ST_TRIM_START;
            end else if (!stat.head_end) begin
               state_in = scbp_pkg::ST_ALLOC_RD;
            end else begin
               state_in = scbp_pkg::ST_REFILL_CHK;
            end
         end
         scbp_pkg::ST_ALLOC_RD: begin
            cmd.op   = scbp_pkg::OP_READ_HEAD;
            state_in = scbp_pkg::ST_ALLOC_POP;
         end
         scbp_pkg::ST_ALLOC_POP: begin
            cmd.op   = scbp_pkg::OP_ALLOC_POP;
            code_in  = scbp_pkg::RSP_OK;
            state_in = scbp_pkg::ST_RESP;
         end
         scbp_pkg::ST_REFILL_CHK: begin
            if (stat.over_budget) begin
               cmd.op      = scbp_pkg::OP_CUR_ZERO;
               trim_all_in = 1'b1;
               state_in    = scbp_pkg::ST_TRIM_START;
            end else begin
               state_in = scbp_pkg::ST_REFILL_START;
            end
         end
         scbp_pkg::ST_REFILL_RECHK: begin
            if (stat.over_budget) begin
               code_in  = scbp_pkg::RSP_NO_SPACE;
               state_in = scbp_pkg::ST_RESP;
            end else begin
               state_in = scbp_pkg::ST_REFILL_START;
            end
         end
         scbp_pkg::ST_REFILL_START: begin
            cmd.op   = scbp_pkg::OP_REFILL_START;
            state_in = scbp_pkg::ST_REFILL_LOOP;
         end
         scbp_pkg::ST_REFILL_LOOP: begin
            if (stat.count_zero) begin
               state_in = scbp_pkg::ST_ALLOC_RD;
            end else if (stat.spare_end) begin
               if (stat.pushed_any) begin
                  state_in = scbp_pkg::ST_ALLOC_RD;
               end else begin
                  code_in  = scbp_pkg::RSP_NO_SPACE;
                  state_in = scbp_pkg::ST_RESP;
               end
            end else begin
               cmd.op   = scbp_pkg::OP_READ_SPARE;
               state_in = scbp_pkg::ST_REFILL_PUSH;
            end
         end
         scbp_pkg::ST_REFILL_PUSH: begin
            cmd.op   = scbp_pkg::OP_REFILL_PUSH;
            state_in = scbp_pkg::ST_REFILL_LOOP;
         end
         scbp_pkg::ST_TRIM_START: begin
            cmd.op   = scbp_pkg::OP_TRIM_START;
            state_in = scbp_pkg::ST_TRIM_LOOP;
         end
         scbp_pkg::ST_TRIM_LOOP: begin
            if (stat.count_zero || stat.head_end) begin
               if (!trim_all_ff) begin
                  code_in  = scbp_pkg::RSP_OK;
                  state_in = scbp_pkg::ST_RESP;
               end else if (stat.cur_last) begin
                  cmd.op   = scbp_pkg::OP_CUR_REQ;
                  state_in = scbp_pkg::ST_REFILL_RECHK;
               end else begin
                  cmd.op   = scbp_pkg::OP_CUR_INC;
                  state_in = scbp_pkg::ST_TRIM_START;
               end
            end else begin
               cmd.op   = scbp_pkg::OP_READ_HEAD;
               state_in = scbp_pkg::ST_TRIM_POP;
            end
         end
         scbp_pkg::ST_TRIM_POP: begin
            cmd.op   = scbp_pkg::OP_TRIM_POP;
            state_in = scbp_pkg::ST_TRIM_LOOP;
         end
         scbp_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = scbp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = scbp_pkg::ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & ~rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_decide: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == scbp_pkg::ST_DECIDE))
      else $error("accepted item did not enter decode");
   a_load_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a waiting item");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == scbp_pkg::ST_IDLE))
      else $error("ready raised outside idle");
`endif

endmodule

// ===== rtl/core/scbp_datapath.sv =====
// ----------------------------------------------------------------------------
// scbp_datapath
// class lists, spare stack, link memory, byte accounting and result register
// ----------------------------------------------------------------------------
module scbp_datapath (
   input  logic               clock,
   input  logic               reset,
   input  scbp_pkg::req_type  req_data,
   input  logic               csr_wr_en,
   input  logic [31:0]        csr_wr_data,
   input  scbp_pkg::cmd_type  cmd,
   output scbp_pkg::stat_type stat,
   output scbp_pkg::rsp_type  rsp_data
);

   localparam int CW = scbp_pkg::CNT_W;
   localparam int LW = scbp_pkg::LINK_W;
   localparam int HW = scbp_pkg::HANDLE_W;
   localparam int FW = scbp_pkg::FB_W;
   localparam int KW = scbp_pkg::CLS_W;

   logic [LW-1:0] head_ff  [scbp_pkg::CLASS_COUNT];
   logic [CW-1:0] free_ff  [scbp_pkg::CLASS_COUNT];
   logic [CW-1:0] total_ff [scbp_pkg::CLASS_COUNT];
   logic [LW-1:0] link_mem [scbp_pkg::HANDLE_COUNT];

   logic [LW-1:0]                 spare_ff;
   logic [scbp_pkg::HELD_W-1:0]   held_ff;
   logic [31:0]                   max_ff;
   logic [HW-1:0]                 init_cnt_ff;
   logic [KW-1:0]                 cur_ff, cls_ff, cls_in;
   logic                          found_ff, found_in;
   logic                          kind_ff;
   logic [HW-1:0]                 rel_h_ff;
   logic [CW-1:0]                 count_ff;
   logic                          pushed_ff;
   logic [LW-1:0]                 rdata_ff;
   logic [HW-1:0]                 alloc_h_ff;
   logic [scbp_pkg::BS_W-1:0]     alloc_sz_ff;
   scbp_pkg::rsp_type             rsp_ff;

   logic [LW-1:0]                 cur_head;
   logic [CW-1:0]                 cur_free, cur_total;
   logic [scbp_pkg::BS_W-1:0]     bs;
   logic [FW-1:0]                 fb, thr, prod, need;
   logic [CW-1:0]                 trim_cnt, delta;
   logic                          mem_we;
   logic [HW-1:0]                 mem_waddr, mem_raddr;
   logic [LW-1:0]                 mem_wdata;

   assign cur_head  = head_ff[cur_ff];
   assign cur_free  = free_ff[cur_ff];
   assign cur_total = total_ff[cur_ff];
   assign bs        = scbp_pkg::class_bytes(cur_ff);

   always_comb begin
      found_in = 1'b0;
      cls_in   = '0;
      for (int c = scbp_pkg::CLASS_COUNT - 1; c >= 0; c--) begin
         if ({7'd0, req_data.size} <= (39'd1 << (scbp_pkg::BASE_SHIFT + c))) begin
            found_in = 1'b1;
            cls_in   = KW'(c);
         end
      end
   end

   always_comb begin
      fb  = FW'(cur_free) << (scbp_pkg::BASE_SHIFT + int'(cur_ff));
      thr = cmd.thr_all ? scbp_pkg::REFILL_THR : FW'(max_ff >> 1);
      trim_cnt = '0;
      if (fb > scbp_pkg::TRIM_FLOOR) begin
         if (cur_ff > KW'(scbp_pkg::MEDIUM_CLASS)) begin
            trim_cnt = CW'(({1'b0, cur_free} + 14'd1) >> 1);
         end else if ((cur_free > (cur_total >> 1)) || (fb > thr)) begin
            trim_cnt = cur_free >> 1;
         end
      end
      if (cur_ff <= KW'(scbp_pkg::SMALL_CLASS)) begin
         delta = CW'(scbp_pkg::REFILL_SMALL);
      end else if (cur_ff <= KW'(scbp_pkg::MEDIUM_CLASS)) begin
         delta = CW'(1) << (scbp_pkg::SPAN_SHIFT - scbp_pkg::BASE_SHIFT - int'(cur_ff));
      end else begin
         delta = CW'(1);
      end
      prod = FW'(delta) << (scbp_pkg::BASE_SHIFT + int'(cur_ff));
      need = FW'(held_ff) + prod;
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cur_head[HW-1:0];
      mem_wdata = spare_ff;
      mem_raddr = cur_head[HW-1:0];
      case (cmd.op)
         scbp_pkg::OP_INIT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = init_cnt_ff;
            mem_wdata = {1'b0, init_cnt_ff} + LW'(1);
         end
         scbp_pkg::OP_TRIM_POP: begin
            mem_we = 1'b1;
         end
         scbp_pkg::OP_READ_SPARE: begin
            mem_raddr = spare_ff[HW-1:0];
         end
         scbp_pkg::OP_REFILL_PUSH: begin
            mem_we    = 1'b1;
            mem_waddr = spare_ff[HW-1:0];
            mem_wdata = cur_head;
         end
         scbp_pkg::OP_RELEASE: begin
            mem_we    = 1'b1;
            mem_waddr = rel_h_ff;
            mem_wdata = cur_head;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) link_mem[mem_waddr] <= mem_wdata;
      rdata_ff <= link_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < scbp_pkg::CLASS_COUNT; c++) begin
            head_ff[c]  <= scbp_pkg::END_MARK;
            free_ff[c]  <= '0;
            total_ff[c] <= '0;
         end
         spare_ff    <= '0;
         held_ff     <= '0;
         max_ff      <= scbp_pkg::POOL_RESET;
         init_cnt_ff <= '0;
         cur_ff      <= '0;
      end else begin
         if (csr_wr_en) max_ff <= csr_wr_data;
         case (cmd.op)
            scbp_pkg::OP_INIT_WR: begin
               init_cnt_ff <= init_cnt_ff + HW'(1);
            end
            scbp_pkg::OP_LOAD: begin
               cur_ff <= cls_in;
            end
            scbp_pkg::OP_RELEASE: begin
               head_ff[cur_ff] <= {1'b0, rel_h_ff};
               free_ff[cur_ff] <= cur_free + CW'(1);
            end
            scbp_pkg::OP_ALLOC_POP: begin
               head_ff[cur_ff] <= rdata_ff;
               free_ff[cur_ff] <= (cur_free != '0) ? cur_free - CW'(1) : '0;
            end
            scbp_pkg::OP_TRIM_POP: begin
               head_ff[cur_ff]  <= rdata_ff;
               spare_ff         <= cur_head;
               free_ff[cur_ff]  <= (cur_free != '0) ? cur_free - CW'(1) : '0;
               total_ff[cur_ff] <= (cur_total != '0) ? cur_total - CW'(1) : '0;
               held_ff <= (held_ff > scbp_pkg::HELD_W'(bs)) ?
                          held_ff - scbp_pkg::HELD_W'(bs) : '0;
            end
            scbp_pkg::OP_REFILL_PUSH: begin
               head_ff[cur_ff]  <= spare_ff;
               spare_ff         <= rdata_ff;
               free_ff[cur_ff]  <= cur_free + CW'(1);
               total_ff[cur_ff] <= cur_total + CW'(1);
               held_ff          <= held_ff + scbp_pkg::HELD_W'(bs);
            end
            scbp_pkg::OP_CUR_ZERO: begin
               cur_ff <= '0;
            end
            scbp_pkg::OP_CUR_INC: begin
               cur_ff <= cur_ff + KW'(1);
            end
            scbp_pkg::OP_CUR_REQ: begin
               cur_ff <= cls_ff;
            end
            default: begin
               cur_ff <= cur_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         scbp_pkg::OP_LOAD: begin
            cls_ff   <= cls_in;
            found_ff <= found_in;
            kind_ff  <= req_data.kind;
            rel_h_ff <= req_data.handle;
         end
         scbp_pkg::OP_TRIM_START: begin
            count_ff <= trim_cnt;
         end
         scbp_pkg::OP_TRIM_POP: begin
            count_ff <= count_ff - CW'(1);
         end
         scbp_pkg::OP_REFILL_START: begin
            count_ff  <= delta;
            pushed_ff <= 1'b0;
         end
         scbp_pkg::OP_REFILL_PUSH: begin
            count_ff  <= count_ff - CW'(1);
            pushed_ff <= 1'b1;
         end
         scbp_pkg::OP_ALLOC_POP: begin
            alloc_h_ff  <= cur_head[HW-1:0];
            alloc_sz_ff <= bs;
         end
         default: begin
            count_ff <= count_ff;
         end
      endcase
      if (cmd.rsp_load) begin
         rsp_ff.status <= cmd.rsp_code;
         if (cmd.rsp_code == scbp_pkg::RSP_OK && !kind_ff) begin
            rsp_ff.granted_handle <= alloc_h_ff;
            rsp_ff.granted_size   <= alloc_sz_ff;
         end else begin
            rsp_ff.granted_handle <= '0;
            rsp_ff.granted_size   <= '0;
         end
      end
   end

   assign rsp_data         = rsp_ff;
   assign stat.init_last   = (init_cnt_ff == HW'(scbp_pkg::HANDLE_COUNT - 1));
   assign stat.found       = found_ff;
   assign stat.is_release  = kind_ff;
   assign stat.head_end    = (cur_head >= scbp_pkg::END_MARK);
   assign stat.spare_end   = (spare_ff >= scbp_pkg::END_MARK);
   assign stat.count_zero  = (count_ff == '0);
   assign stat.pushed_any  = pushed_ff;
   assign stat.over_budget = (need > FW'(max_ff));
   assign stat.cur_last    = (cur_ff == KW'(scbp_pkg::CLASS_COUNT - 1));

`ifndef SYNTHESIS
   a_trim_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == scbp_pkg::OP_TRIM_POP) |-> !stat.head_end)
      else $error("trim popped an empty class list");
   a_refill_spare: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == scbp_pkg::OP_REFILL_PUSH) |-> !stat.spare_end)
      else $error("refill popped an empty spare stack");
   a_alloc_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == scbp_pkg::OP_ALLOC_POP) |-> !stat.head_end)
      else $error("allocate popped an empty class list");
`endif

endmodule

// ===== rtl/core/size_class_block_pool_core.sv =====
// ----------------------------------------------------------------------------
// size_class_block_pool_core
// power-of-two size class buffer handle pool with spare stack refill and trim
//
//   channel   ports                         handshake
//   request   req_valid req_ready req_data  valid / ready
//   response  rsp_valid rsp_ready rsp_data  valid / ready
//   config    csr_wr_en csr_wr_data         write enable, no wait
//
// after reset an init pass writes all 4096 link memory entries, no items taken
// an item moves handles one at a time through the link memory, which has one
// read and one write port; refill may first trim every class, then moves up
// to 128 handles from the spare stack
// a new item is taken while a finished result still waits on rsp
// ----------------------------------------------------------------------------
module size_class_block_pool_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  scbp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output scbp_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data
);

   scbp_pkg::cmd_type  cmd;
   scbp_pkg::stat_type stat;

   scbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   scbp_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== tb/size_class_block_pool_checker.sv =====
// ----------------------------------------------------------------------------
// size_class_block_pool_checker
// watches the request and response channels, keeps its own copy of the pool
// state, predicts each response and compares it field by field
// ----------------------------------------------------------------------------
module size_class_block_pool_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  scbp_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  scbp_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data,
   output int                fail_count,
   output int                pending
);

   logic [31:0]       budget;
   logic [12:0]       head_of[scbp_pkg::CLASS_COUNT];
   logic [12:0]       free_of[scbp_pkg::CLASS_COUNT];
   logic [12:0]       total_of[scbp_pkg::CLASS_COUNT];
   logic [12:0]       next_of[scbp_pkg::HANDLE_COUNT];
   logic [12:0]       spare_top;
   logic [63:0]       held;
   scbp_pkg::rsp_type expected_q[$];

   assign pending = expected_q.size();

   function automatic logic [63:0] block_bytes(int c);
      return 64'd1 << (10 + c);
   endfunction

   function automatic logic [12:0] dec_floor(logic [12:0] v);
      return (v != 0) ? v - 13'd1 : 13'd0;
   endfunction

   task automatic shrink_class(int c, logic [63:0] limit);
      logic [63:0] bs;
      logic [63:0] fb;
      int          n;
      logic [12:0] h;
      bs = block_bytes(c);
      fb = bs * free_of[c];
      n = 0;
      if (fb > 64'd262144) begin
         if (bs > 64'd8388608) n = (int'(free_of[c]) + 1) / 2;
         else if (free_of[c] > total_of[c] / 2 || fb > limit) n = free_of[c] / 2;
      end
      for (int j = 0; j < n && head_of[c] < scbp_pkg::HANDLE_COUNT; j++) begin
         h = head_of[c];
         head_of[c] = next_of[h];
         next_of[h] = spare_top;
         spare_top = h;
         total_of[c] = dec_floor(total_of[c]);
         free_of[c] = dec_floor(free_of[c]);
         held = (held > bs) ? held - bs : 64'd0;
      end
   endtask

   task automatic grow_class(int c, output bit ok);
      logic [63:0] bs;
      int          delta;
      logic [12:0] e;
      bs = block_bytes(c);
      if (bs <= 64'd131072) delta = 128;
      else if (bs <= 64'd8388608) delta = int'(64'd16777216 / bs);
      else delta = 1;
      ok = 1;
      if (held + bs * delta > {32'd0, budget})
         for (int i = 0; i < scbp_pkg::CLASS_COUNT; i++) shrink_class(i, 64'd16777216);
      if (held + bs * delta > {32'd0, budget}) begin
         ok = 0;
         return;
      end
      for (int i = 0; i < delta; i++) begin
         e = spare_top;
         if (e >= scbp_pkg::HANDLE_COUNT) begin
            if (i == 0) ok = 0;
            return;
         end
         spare_top = next_of[e];
         next_of[e] = head_of[c];
         head_of[c] = e;
         total_of[c]++;
         free_of[c]++;
         held += bs;
      end
   endtask

   task automatic predict_response(scbp_pkg::req_type r);
      scbp_pkg::rsp_type o;
      int                c;
      bit                ok;
      logic [12:0]       h;
      o = '0;
      c = -1;
      for (int i = 0; i < scbp_pkg::CLASS_COUNT; i++)
         if (c < 0 && {32'd0, r.size} <= block_bytes(i)) c = i;
      if (c < 0) begin
         o.status = scbp_pkg::RSP_NO_FIT;
      end else if (!r.kind) begin
         ok = 1;
         if (head_of[c] >= scbp_pkg::HANDLE_COUNT) begin
            grow_class(c, ok);
            if (head_of[c] >= scbp_pkg::HANDLE_COUNT) ok = 0;
         end
         if (!ok) begin
            o.status = scbp_pkg::RSP_NO_SPACE;
         end else begin
            h = head_of[c];
            head_of[c] = next_of[h];
            free_of[c] = dec_floor(free_of[c]);
            o.status = scbp_pkg::RSP_OK;
            o.granted_handle = h[11:0];
            o.granted_size = 26'(block_bytes(c));
         end
      end else begin
         next_of[r.handle] = head_of[c];
         head_of[c] = {1'b0, r.handle};
         free_of[c]++;
         shrink_class(c, {32'd0, budget} / 2);
         o.status = scbp_pkg::RSP_OK;
      end
      expected_q.push_back(o);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         budget = scbp_pkg::POOL_RESET;
         for (int i = 0; i < scbp_pkg::CLASS_COUNT; i++) begin
            head_of[i] = 13'(scbp_pkg::HANDLE_COUNT);
            free_of[i] = '0;
            total_of[i] = '0;
         end
         for (int i = 0; i < scbp_pkg::HANDLE_COUNT; i++) next_of[i] = 13'(i + 1);
         spare_top = '0;
         held = '0;
         expected_q.delete();
         fail_count = 0;
      end else begin
         if (csr_wr_en) budget = csr_wr_data;
         if (req_valid && req_ready) predict_response(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("response with none expected: %p", rsp_data);
               fail_count++;
            end else begin
               scbp_pkg::rsp_type e;
               e = expected_q.pop_front();
               if (rsp_data.status !== e.status) begin
                  $error("status expected %0d actual %0d", e.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.granted_handle !== e.granted_handle) begin
                  $error("granted_handle expected %0d actual %0d",
                         e.granted_handle, rsp_data.granted_handle);
                  fail_count++;
               end
               if (rsp_data.granted_size !== e.granted_size) begin
                  $error("granted_size expected %0d actual %0d",
                         e.granted_size, rsp_data.granted_size);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

// ===== tb/size_class_block_pool_core_tb.sv =====
// ----------------------------------------------------------------------------
// size_class_block_pool_core_tb
// drives allocate and release items with random bursts and response stalls,
// changes the byte budget between phases and reports the checker's verdict
// ----------------------------------------------------------------------------
module size_class_block_pool_core_tb;

   localparam int IDLE_LIMIT = 100000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   scbp_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   scbp_pkg::rsp_type rsp_data;
   logic              csr_wr_en;
   logic [31:0]       csr_wr_data;
   int                fail_count;
   int                pending;
   int                idle_cycles;
   int                stall_mode;
   logic [11:0]       held_handles[$];
   logic [25:0]       held_sizes[$];

   size_class_block_pool_core uut (.*);

   size_class_block_pool_checker checker_i (.*);

   initial clock = 0;
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // response stall pattern, mode changes from time to time
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b1;
         stall_mode <= 0;
      end else begin
         if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ready <= ($urandom_range(0, 1) != 0);
            default: rsp_ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // keep handles of granted blocks so releases are mostly well formed
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready && rsp_data.status == scbp_pkg::RSP_OK &&
          rsp_data.granted_size != 0) begin
         held_handles.push_back(rsp_data.granted_handle);
         held_sizes.push_back(rsp_data.granted_size);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_item(logic kind, logic [31:0] size, logic [11:0] handle);
      req_data <= '{kind: kind, size: size, handle: handle};
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_random;
      int pick;
      int k;
      logic [31:0] sz;
      pick = $urandom_range(0, 99);
      if (pick < 40 && held_handles.size() > 0) begin
         k = $urandom_range(0, held_handles.size() - 1);
         send_item(1'b1, 32'(held_sizes[k]), held_handles[k]);
         held_handles.delete(k);
         held_sizes.delete(k);
      end else if (pick < 90) begin
         // mostly small classes, a few large
         if ($urandom_range(0, 9) != 0) sz = $urandom_range(0, 32'd1 << ($urandom_range(0, 17)));
         else sz = $urandom_range(0, 32'd1 << ($urandom_range(18, 25)));
         send_item(1'b0, sz, 12'($urandom));
      end else begin
         send_item(1'($urandom_range(0, 1)), $urandom, 12'($urandom));
      end
   endtask

   task automatic wait_drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0 || !req_ready) @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   task automatic write_budget(logic [31:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_phase(int n);
      int burst;
      while (n > 0) begin
         burst = $urandom_range(1, 20);
         while (burst > 0 && n > 0) begin
            send_random();
            burst--;
            n--;
         end
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: class edges, no fit, bad handle, large and huge classes
      send_item(1'b0, 32'd0, 12'd0);
      send_item(1'b0, 32'd1024, 12'hfff);
      send_item(1'b0, 32'd1025, 12'd0);
      send_item(1'b0, 32'd131072, 12'd0);
      send_item(1'b0, 32'd131073, 12'd0);
      send_item(1'b0, 32'd8388608, 12'd0);
      send_item(1'b0, 32'd16777216, 12'd0);
      send_item(1'b0, 32'd33554432, 12'd0);
      send_item(1'b0, 32'd33554433, 12'd0);
      send_item(1'b0, 32'hffff_ffff, 12'd0);
      send_item(1'b1, 32'hffff_ffff, 12'd5);
      send_item(1'b1, 32'd1024, 12'hfff);
      send_item(1'b1, 32'd1024, 12'd0);
      send_item(1'b1, 32'd1024, 12'd0);
      send_item(1'b1, 32'd33554432, 12'd3);
      send_item(1'b1, 32'd2048, 12'd4095);
      wait_drain();

      write_budget(32'd0);
      send_item(1'b0, 32'd100, 12'd0);
      send_item(1'b0, 32'd33554432, 12'd0);
      wait_drain();

      write_budget(32'hffff_ffff);
      random_phase(300);
      wait_drain();
      write_budget(32'd4194304);
      random_phase(200);
      wait_drain();
      write_budget(32'd67108864);
      random_phase(200);
      wait_drain();
      write_budget($urandom);
      random_phase(230);
      wait_drain();

      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== size_class_block_pool_core.f =====
rtl/core/scbp_pkg.sv
rtl/core/scbp_ctrl.sv
rtl/core/scbp_datapath.sv
rtl/core/size_class_block_pool_core.sv
tb/size_class_block_pool_checker.sv
tb/size_class_block_pool_core_tb.sv
